FILE: rtl/lfu_pkg.sv
// Package with the transaction, scan and update types of the LFU cache table.
package lfu_pkg;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 32;
  localparam int IDX_W      = 8;
  localparam int RANK_W     = 9;
  localparam logic       CMD_GET   = 1'b0;
  localparam logic       CMD_PUT   = 1'b1;
  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic                         cmd;
    logic signed [KEY_BITS-1:0]   lookup_key;
    logic signed [VALUE_BITS-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
    logic                         evicted;
    logic signed [KEY_BITS-1:0]   evicted_key;
  } out_item_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      found_idx;
    logic [RANK_W-1:0]     found_age;
    logic [VALUE_BITS-1:0] found_value;
    logic [RANK_W-1:0]     count;
    logic                  vic_ok;
    logic [IDX_W-1:0]      vic_idx;
    logic [COUNT_BITS-1:0] vic_cnt;
    logic [RANK_W-1:0]     vic_age;
    logic [KEY_BITS-1:0]   vic_key;
    logic                  free_ok;
    logic [IDX_W-1:0]      free_idx;
  } scan_t;

  typedef struct packed {
    logic                  en;
    logic                  insert;
    logic                  wr_value;
    logic [IDX_W-1:0]      target;
    logic [RANK_W-1:0]     thresh;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } upd_t;
endpackage

FILE: rtl/lfu_cell.sv
// One cache entry with its stage of the lookup and victim scan chain.
module lfu_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [lfu_pkg::KEY_BITS-1:0]    key_i,
  input  lfu_pkg::scan_t                  scan_i,
  output lfu_pkg::scan_t                  scan_o,
  input  lfu_pkg::upd_t                   upd_i
);
  logic                             valid_r;
  logic [lfu_pkg::KEY_BITS-1:0]     key_r;
  logic [lfu_pkg::VALUE_BITS-1:0]   value_r;
  logic [lfu_pkg::COUNT_BITS-1:0]   cnt_r;
  logic [lfu_pkg::RANK_W-1:0]       age_r;
  lfu_pkg::scan_t                   scan_r, scan_nxt;
  logic                             me;
  localparam logic [lfu_pkg::IDX_W-1:0] MY_IDX = lfu_pkg::IDX_W'(IDX);

  assign me = upd_i.en && (upd_i.target == MY_IDX);

  always_comb begin
    scan_nxt = scan_i;
    if (valid_r) begin
      scan_nxt.count = scan_i.count + 1'b1;
      if (!scan_i.found && key_r == key_i) begin
        scan_nxt.found       = 1'b1;
        scan_nxt.found_idx   = MY_IDX;
        scan_nxt.found_age   = age_r;
        scan_nxt.found_value = value_r;
      end
      if (!scan_i.vic_ok || cnt_r < scan_i.vic_cnt ||
          (cnt_r == scan_i.vic_cnt && age_r > scan_i.vic_age)) begin
        scan_nxt.vic_ok  = 1'b1;
        scan_nxt.vic_idx = MY_IDX;
        scan_nxt.vic_cnt = cnt_r;
        scan_nxt.vic_age = age_r;
        scan_nxt.vic_key = key_r;
      end
    end else if (!scan_i.free_ok) begin
      scan_nxt.free_ok  = 1'b1;
      scan_nxt.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    if (me) begin
      key_r   <= upd_i.insert ? upd_i.key : key_r;
      value_r <= (upd_i.insert || upd_i.wr_value) ? upd_i.value : value_r;
      age_r   <= '0;
      if (upd_i.insert) begin
        cnt_r <= lfu_pkg::COUNT_BITS'(1);
      end else if (cnt_r != '1) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end else if (upd_i.en && valid_r && age_r < upd_i.thresh) begin
      age_r <= age_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (me && upd_i.insert) begin
      valid_r <= 1'b1;
    end
  end

  assign scan_o = scan_r;
endmodule

FILE: rtl/lfu_cache_table.sv
// Top level of the LFU cache table: control, scan chain and result register.
// The block is a fully associative key/value store with least-frequently-used
// replacement and a least-recently-used tie break.
// Requests arrive on in_valid/in_ready with in_data (get or put of a key).
// Each transaction yields one result on out_valid/out_ready with out_data:
// hit flag, read value, eviction flag and evicted key.
// A request is accepted only when the controller is idle. The lookup walks a
// chain of MAX_ENTRIES cells, one cell per cycle; the update state then loads
// the result and updates the entries, so a new request is taken only after the
// previous transaction has left the update state.
// The result sits in an output register, so the next request may be taken
// while a result waits; if the receiver stalls, the following update waits
// until the register frees up.
// cfg_we with cfg_wdata sets the capacity; write it only while idle.
// Synchronous reset clears every entry and sets the capacity to 16.
module lfu_cache_table #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lfu_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [1:0] ST_IDLE = 2'd0, ST_SCAN = 2'd1, ST_UPD = 2'd2;
  localparam logic [CW-1:0] SCAN_LAST = CW'(MAX_ENTRIES);

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [4:0]          cap_r;
  logic [lfu_pkg::RANK_W-1:0] cap_eff;
  lfu_pkg::in_item_t   item_r;
  lfu_pkg::out_item_t  res, out_r;
  logic                out_valid_r;
  lfu_pkg::upd_t       upd;
  lfu_pkg::scan_t      chain [MAX_ENTRIES+1];
  lfu_pkg::scan_t      fin;
  logic                fire;

  assign chain[0] = '0;
  assign fin      = chain[MAX_ENTRIES];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lfu_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .key_i(item_r.lookup_key),
      .scan_i(chain[g]), .scan_o(chain[g+1]), .upd_i(upd)
    );
  end

  assign cap_eff = (32'(cap_r) > MAX_ENTRIES) ? lfu_pkg::RANK_W'(MAX_ENTRIES)
                                              : lfu_pkg::RANK_W'(cap_r);
  assign fire     = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    res        = '0;
    upd        = '0;
    upd.key    = item_r.lookup_key;
    upd.value  = item_r.write_value;
    if (item_r.cmd == lfu_pkg::CMD_GET) begin
      res.read_value = '1;
    end
    if (cap_eff != '0) begin
      if (fin.found) begin
        res.hit        = 1'b1;
        upd.en         = fire;
        upd.target     = fin.found_idx;
        upd.thresh     = fin.found_age;
        upd.wr_value   = (item_r.cmd == lfu_pkg::CMD_PUT);
        if (item_r.cmd == lfu_pkg::CMD_GET) begin
          res.read_value = fin.found_value;
        end
      end else if (item_r.cmd == lfu_pkg::CMD_PUT) begin
        if (fin.count >= cap_eff && fin.vic_ok) begin
          res.evicted     = 1'b1;
          res.evicted_key = fin.vic_key;
          upd.en          = fire;
          upd.insert      = 1'b1;
          upd.target      = fin.vic_idx;
          upd.thresh      = fin.vic_age;
        end else if (fin.free_ok) begin
          upd.en     = fire;
          upd.insert = 1'b1;
          upd.target = fin.free_idx;
          upd.thresh = lfu_pkg::RANK_W'(MAX_ENTRIES);
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SCAN_LAST - 1'b1) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cap_r       <= lfu_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCAN))
    else $error("accepted transaction did not start a scan");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r < SCAN_LAST))
    else $error("scan counter out of range");
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.evicted && out_r.hit))
    else $error("eviction reported on a hit");
  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("finished transaction not presented");
`endif
endmodule
